@@ rtl/alsc_pkg.sv @@
// ----------------------------------------------------------------------------
// alsc_pkg
// Shared types and constants for the alternating-step LFSR stream cipher:
// opcodes, register masks and default key words.
// ----------------------------------------------------------------------------
package alsc_pkg;

  localparam int WORD_W = 32;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [OP_W-1:0]   opcode_t;

  localparam opcode_t OP_TRANSFORM = 2'd0;
  localparam opcode_t OP_LOAD_KEY  = 2'd1;
  localparam opcode_t OP_LOAD_RAW  = 2'd2;

  localparam word_t MASK_A = 32'h8000_0062;
  localparam word_t MASK_B = 32'h4000_0020;
  localparam word_t MASK_C = 32'h1000_0002;
  localparam word_t ONES_A = 32'h8000_0000;
  localparam word_t ONES_B = 32'hC000_0000;
  localparam word_t ONES_C = 32'hF000_0000;
  localparam word_t KEEP_A = 32'h7FFF_FFFF;
  localparam word_t KEEP_B = 32'h3FFF_FFFF;
  localparam word_t KEEP_C = 32'h0FFF_FFFF;
  localparam word_t DEF_A  = 32'hAFCE_1246;
  localparam word_t DEF_B  = 32'h990F_D227;
  localparam word_t DEF_C  = 32'hF39B_CD44;

  function automatic word_t clock_reg(input word_t r, input word_t m,
                                      input word_t k1, input word_t k0);
    word_t res;
    if (r[0]) begin
      res = ((r ^ m) >> 1) | k1;
    end else begin
      res = (r >> 1) & k0;
    end
    return res;
  endfunction

endpackage

@@ rtl/alsc_in_if.sv @@
// ----------------------------------------------------------------------------
// alsc_in_if
// Input channel of the stream cipher: valid/ready handshake with one
// opcode, data byte and three key or register words per transaction.
// ----------------------------------------------------------------------------
interface alsc_in_if
  import alsc_pkg::*;
();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  byte_t   data_byte;
  word_t   word_a;
  word_t   word_b;
  word_t   word_c;

  modport source (output valid, output opcode, output data_byte,
                  output word_a, output word_b, output word_c, input ready);
  modport sink   (input valid, input opcode, input data_byte,
                  input word_a, input word_b, input word_c, output ready);
endinterface

@@ rtl/alsc_out_if.sv @@
// ----------------------------------------------------------------------------
// alsc_out_if
// Result channel of the stream cipher: valid/ready handshake with the
// transformed byte, the three registers and the byte count.
// ----------------------------------------------------------------------------
interface alsc_out_if
  import alsc_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_out;
  word_t reg_a_out;
  word_t reg_b_out;
  word_t reg_c_out;
  word_t bytes_done;

  modport source (output valid, output data_out, output reg_a_out,
                  output reg_b_out, output reg_c_out, output bytes_done,
                  input ready);
  modport sink   (input valid, input data_out, input reg_a_out,
                  input reg_b_out, input reg_c_out, input bytes_done,
                  output ready);
endinterface

@@ rtl/alternating_lfsr_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// alternating_lfsr_stream_cipher
// Alternating-step LFSR stream cipher with key load and raw register load.
// ----------------------------------------------------------------------------
// The eight keystream steps of a byte are unrolled between the state
// registers and the result register, so a new transaction is accepted every
// cycle while the result side keeps taking results. Each input transaction
// yields exactly one result, in the next cycle at the earliest; the input is
// stalled only while a result waits unread.
module alternating_lfsr_stream_cipher
  import alsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  alsc_in_if.sink    in_chan,
  alsc_out_if.source out_chan
);

  word_t lfsr_a_r, lfsr_b_r, lfsr_c_r, count_r;
  word_t lfsr_a_nxt, lfsr_b_nxt, lfsr_c_nxt, count_nxt;
  byte_t dout_nxt;

  logic  out_valid_r;
  byte_t data_out_r;
  word_t reg_a_out_r, reg_b_out_r, reg_c_out_r, bytes_done_r;

  word_t ks_a, ks_b, ks_c;
  byte_t ks_byte;
  logic  in_fire;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // eight unrolled keystream steps
  always_comb begin
    word_t a, b, c;
    logic  ob, oc;
    byte_t ks;
    a  = lfsr_a_r;
    b  = lfsr_b_r;
    c  = lfsr_c_r;
    ob = lfsr_b_r[0];
    oc = lfsr_c_r[0];
    ks = '0;
    for (int n = 0; n < BYTE_W; n++) begin
      if (a[0]) begin
        ob = b[0];
        b  = clock_reg(b, MASK_B, ONES_B, KEEP_B);
      end else begin
        oc = c[0];
        c  = clock_reg(c, MASK_C, ONES_C, KEEP_C);
      end
      a  = clock_reg(a, MASK_A, ONES_A, KEEP_A);
      ks = {ks[BYTE_W-2:0], ob ^ oc};
    end
    ks_a    = a;
    ks_b    = b;
    ks_c    = c;
    ks_byte = ks;
  end

  always_comb begin
    lfsr_a_nxt = lfsr_a_r;
    lfsr_b_nxt = lfsr_b_r;
    lfsr_c_nxt = lfsr_c_r;
    count_nxt  = count_r;
    dout_nxt   = '0;
    case (in_chan.opcode)
      OP_TRANSFORM: begin
        lfsr_a_nxt = ks_a;
        lfsr_b_nxt = ks_b;
        lfsr_c_nxt = ks_c;
        count_nxt  = count_r + word_t'(1);
        dout_nxt   = in_chan.data_byte ^ ks_byte;
      end
      OP_LOAD_KEY: begin
        lfsr_a_nxt = (in_chan.word_a != '0) ? in_chan.word_a : DEF_A;
        lfsr_b_nxt = (in_chan.word_b != '0) ? in_chan.word_b : DEF_B;
        lfsr_c_nxt = (in_chan.word_c != '0) ? in_chan.word_c : DEF_C;
        count_nxt  = '0;
      end
      OP_LOAD_RAW: begin
        lfsr_a_nxt = in_chan.word_a;
        lfsr_b_nxt = in_chan.word_b;
        lfsr_c_nxt = in_chan.word_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_a_r    <= '0;
      lfsr_b_r    <= '0;
      lfsr_c_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        lfsr_a_r    <= lfsr_a_nxt;
        lfsr_b_r    <= lfsr_b_nxt;
        lfsr_c_r    <= lfsr_c_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_out_r   <= dout_nxt;
      reg_a_out_r  <= lfsr_a_nxt;
      reg_b_out_r  <= lfsr_b_nxt;
      reg_c_out_r  <= lfsr_c_nxt;
      bytes_done_r <= count_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.data_out   = data_out_r;
  assign out_chan.reg_a_out  = reg_a_out_r;
  assign out_chan.reg_b_out  = reg_b_out_r;
  assign out_chan.reg_c_out  = reg_c_out_r;
  assign out_chan.bytes_done = bytes_done_r;

endmodule

@@ tb/tb_alternating_lfsr_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// tb_alternating_lfsr_stream_cipher
// Self-checking bench for the alternating-step LFSR stream cipher. A
// scoreboard class keeps its own copy of the three shift registers and the
// byte counter, predicts every result from each accepted input transaction
// and compares the results field by field in order. Directed key loads,
// raw loads, no-ops and transforms come first, then a long random mix under
// changing idle patterns and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_alternating_lfsr_stream_cipher;
  import alsc_pkg::*;

  localparam opcode_t OP_NOP       = 2'd3;
  localparam int      RANDOM_ITEMS = 1550;
  localparam int      PHASE_LEN    = 517;
  localparam int      HOLD_AT      = 1300;
  localparam int      HOLD_CYCLES  = 300;
  localparam int      DRAIN_CYCLES = 20;
  localparam int      CYCLE_LIMIT  = 200000;

  typedef struct packed {
    byte_t data_out;
    word_t reg_a;
    word_t reg_b;
    word_t reg_c;
    word_t bytes_done;
  } cipher_result_t;

  class cipher_scoreboard;
    word_t          reg_a;
    word_t          reg_b;
    word_t          reg_c;
    word_t          byte_count;
    cipher_result_t expected_q[$];
    int             errors;

    function new();
      reg_a      = '0;
      reg_b      = '0;
      reg_c      = '0;
      byte_count = '0;
      errors     = 0;
    endfunction

    function word_t advance(word_t r, word_t m, word_t k1, word_t k0);
      return r[0] ? (((r ^ m) >> 1) | k1) : ((r >> 1) & k0);
    endfunction

    function byte_t keystream_byte();
      byte_t ks;
      bit    ob;
      bit    oc;
      bit    a_low;
      int    n;
      ks = '0;
      ob = reg_b[0];
      oc = reg_c[0];
      for (n = 0; n < 8; n++) begin
        a_low = reg_a[0];
        reg_a = advance(reg_a, MASK_A, ONES_A, KEEP_A);
        if (a_low) begin
          ob    = reg_b[0];
          reg_b = advance(reg_b, MASK_B, ONES_B, KEEP_B);
        end else begin
          oc    = reg_c[0];
          reg_c = advance(reg_c, MASK_C, ONES_C, KEEP_C);
        end
        ks = {ks[6:0], ob ^ oc};
      end
      return ks;
    endfunction

    function void note_input(opcode_t op, byte_t db, word_t wa, word_t wb, word_t wc);
      cipher_result_t r;
      r.data_out = '0;
      case (op)
        OP_TRANSFORM: begin
          r.data_out = db ^ keystream_byte();
          byte_count = byte_count + 1;
        end
        OP_LOAD_KEY: begin
          reg_a      = (wa != 0) ? wa : DEF_A;
          reg_b      = (wb != 0) ? wb : DEF_B;
          reg_c      = (wc != 0) ? wc : DEF_C;
          byte_count = '0;
        end
        OP_LOAD_RAW: begin
          reg_a = wa;
          reg_b = wb;
          reg_c = wc;
        end
        default: begin
        end
      endcase
      r.reg_a      = reg_a;
      r.reg_b      = reg_b;
      r.reg_c      = reg_c;
      r.bytes_done = byte_count;
      expected_q.push_back(r);
    endfunction

    function void check_result(byte_t d, word_t a, word_t b, word_t c, word_t n);
      cipher_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: data_out %h", d);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data_out) begin
        $error("data_out expected %h actual %h", e.data_out, d);
        errors++;
      end
      if (a !== e.reg_a) begin
        $error("reg_a_out expected %h actual %h", e.reg_a, a);
        errors++;
      end
      if (b !== e.reg_b) begin
        $error("reg_b_out expected %h actual %h", e.reg_b, b);
        errors++;
      end
      if (c !== e.reg_c) begin
        $error("reg_c_out expected %h actual %h", e.reg_c, c);
        errors++;
      end
      if (n !== e.bytes_done) begin
        $error("bytes_done expected %h actual %h", e.bytes_done, n);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  alsc_in_if  in_chan();
  alsc_out_if out_chan();

  alternating_lfsr_stream_cipher i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cipher_scoreboard sb;
  int               results_seen;
  int               hold_left;
  bit               held;
  int               cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int send_idle_pct(int idx);
    if (idx < PHASE_LEN) return 16;
    if (idx < 2 * PHASE_LEN) return 62;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int seen);
    if (seen < 25 + PHASE_LEN) return 62;
    if (seen < 25 + 2 * PHASE_LEN) return 16;
    return 0;
  endfunction

  task automatic send_item(opcode_t op, byte_t db, word_t wa, word_t wb, word_t wc,
                           int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.opcode    <= op;
    in_chan.data_byte <= db;
    in_chan.word_a    <= wa;
    in_chan.word_b    <= wb;
    in_chan.word_c    <= wc;
    in_chan.valid     <= 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_input(op, db, wa, wb, wc);
  endtask

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        sb.check_result(out_chan.data_out, out_chan.reg_a_out, out_chan.reg_b_out,
                        out_chan.reg_c_out, out_chan.bytes_done);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (results_seen >= HOLD_AT && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct(results_seen));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int      i;
    int      sel;
    opcode_t op;
    sb                = new();
    results_seen      = 0;
    hold_left         = 0;
    held              = 1'b0;
    cycle_count       = 0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.opcode    = OP_TRANSFORM;
    in_chan.data_byte = '0;
    in_chan.word_a    = '0;
    in_chan.word_b    = '0;
    in_chan.word_c    = '0;
    out_chan.ready    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero state straight out of reset
    send_item(OP_TRANSFORM, 8'h00, '0, '0, '0, 16);
    send_item(OP_TRANSFORM, 8'hFF, '1, '1, '1, 16);
    // zero key words fall back to defaults
    send_item(OP_LOAD_KEY, 8'hFF, '0, '0, '0, 16);
    send_item(OP_TRANSFORM, 8'h00, '0, '0, '0, 16);
    send_item(OP_TRANSFORM, 8'hFF, '0, '0, '0, 16);
    send_item(OP_TRANSFORM, 8'hA5, '1, '1, '1, 16);
    send_item(OP_LOAD_KEY, 8'h00, '1, '1, '1, 16);
    send_item(OP_TRANSFORM, 8'h5A, '0, '0, '0, 16);
    send_item(OP_LOAD_KEY, 8'h00, '0, 32'h0123_4567, 32'h89AB_CDEF, 16);
    send_item(OP_TRANSFORM, 8'h3C, '0, '0, '0, 16);
    send_item(OP_LOAD_KEY, 8'h00, 32'hDEAD_BEEF, '0, 32'h0000_0001, 16);
    send_item(OP_TRANSFORM, 8'hC3, '0, '0, '0, 16);
    send_item(OP_LOAD_KEY, 8'h00, 32'h8000_0000, 32'h0000_0001, '0, 16);
    send_item(OP_TRANSFORM, 8'h01, '0, '0, '0, 16);
    // raw load keeps the counter and takes zero words as they are
    send_item(OP_LOAD_RAW, 8'hFF, '0, '0, '0, 16);
    send_item(OP_TRANSFORM, 8'h80, '0, '0, '0, 16);
    send_item(OP_LOAD_RAW, 8'h00, '1, '1, '1, 16);
    send_item(OP_TRANSFORM, 8'h7F, '0, '0, '0, 16);
    send_item(OP_LOAD_RAW, 8'h00, 32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 16);
    send_item(OP_TRANSFORM, 8'hFF, '0, '0, '0, 16);
    // no-op leaves the state alone
    send_item(OP_NOP, 8'hFF, '1, '1, '1, 16);
    send_item(OP_NOP, 8'h00, '0, '0, '0, 16);
    send_item(OP_TRANSFORM, 8'h00, '0, '0, '0, 16);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(99);
      if (sel < 80) op = OP_TRANSFORM;
      else if (sel < 90) op = OP_LOAD_KEY;
      else if (sel < 96) op = OP_LOAD_RAW;
      else op = OP_NOP;
      send_item(op, byte_t'($urandom_range(255)), pick_word(), pick_word(), pick_word(),
                send_idle_pct(i));
    end
    in_chan.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
